// File: rtl/tmp_pkg.sv
// Shared types and constants for the trapezoidal motion profile block.
// No dependencies; used by trapezoidal_motion_profile and the testbench.
package tmp_pkg;

  localparam int unsigned POS_W   = 32;   // Q16.16 position and velocity width
  localparam int unsigned T_W     = 16;   // millisecond time width
  localparam int unsigned QUO_W   = 32;   // quotient bits per division
  localparam int unsigned APOS_W  = 34;   // position numerator factor width
  localparam int unsigned AVEL_W  = 27;   // velocity numerator factor width
  localparam int unsigned IDX_W   = 2;

  localparam logic [T_W-1:0] DUR_RESET = T_W'(1000);
  localparam int unsigned K_CRUISE = 1500;
  localparam int unsigned K_RAMP   = 4500;

  typedef enum logic [IDX_W-1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_DUR   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_RAMP_UP   = 2'd0,
    PH_CRUISE    = 2'd1,
    PH_RAMP_DOWN = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t ph;
    logic   neg;
    logic   sat;
  } side_t;

endpackage

// File: rtl/tmp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the caller keeps num/den such that the quotient fits QUO_W bits.
module tmp_div #(
  parameter int unsigned NUM_W = 66,
  parameter int unsigned DEN_W = 34,
  parameter int unsigned QUO_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned HI_W = NUM_W - QUO_W;
  localparam int unsigned RW   = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [RW-1:0]    rem_r [QUO_W];
  logic [QUO_W-1:0] lo_r  [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W];

  genvar k;
  generate
    for (k = 0; k < QUO_W; k++) begin : g_stage
      logic [RW-1:0]    rem_in;
      logic [QUO_W-1:0] lo_in;
      logic [QUO_W-1:0] q_in;
      logic [RW:0]      trial;
      logic [RW:0]      den_x;
      logic             ge;
      logic [RW-1:0]    rem_nxt;

      if (k == 0) begin : g_first
        assign rem_in = RW'(num[NUM_W-1:QUO_W]);
        assign lo_in  = num[QUO_W-1:0];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign lo_in  = lo_r[k-1];
        assign q_in   = q_r[k-1];
      end

      always_comb begin
        trial   = {rem_in, lo_in[QUO_W-1]};
        den_x   = (RW+1)'(den);
        ge      = (trial >= den_x);
        rem_nxt = ge ? RW'(trial - den_x) : RW'(trial);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          lo_r[k]  <= {lo_in[QUO_W-2:0], 1'b0};
          q_r[k]   <= {q_in[QUO_W-2:0], ge};
        end
      end
    end
  endgenerate

  assign quo = q_r[QUO_W-1];

endmodule

// File: rtl/trapezoidal_motion_profile.sv
// Trapezoidal velocity profile: set-point position, velocity and phase per time tick.
// Depends on tmp_pkg and tmp_div.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid/in_stall   | in_elapsed_ms[15:0]
//  out     | output    | out_valid/out_stall | out_target_position, out_target_velocity,
//          |           |                     | out_move_phase
//  cfg     | input     | cfg_we              | cfg_index[1:0], cfg_wdata[31:0]
//
// One item per cycle while the output is not stalled; each item passes four front stages,
// thirty-two divider stages of one quotient bit each, then one output register.
// The whole pipeline advances as one; it halts only while a finished item waits at
// the output under out_stall, and in_stall is raised for exactly those cycles.
// Reset (synchronous, rst_n low) empties the pipeline and loads start 0, end 0,
// duration 1000 ms.
module trapezoidal_motion_profile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tmp_pkg::T_W-1:0]     in_elapsed_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [tmp_pkg::POS_W-1:0] out_target_position,
  output logic signed [tmp_pkg::POS_W-1:0] out_target_velocity,
  output logic [1:0]                  out_move_phase,
  input  logic                        cfg_we,
  input  logic [tmp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tmp_pkg::POS_W-1:0]   cfg_wdata
);
  import tmp_pkg::*;

  localparam int unsigned NUMP_W = POS_W + APOS_W;   // position numerator
  localparam int unsigned NUMV_W = POS_W + AVEL_W;   // velocity numerator
  localparam int unsigned DENP_W = 2*T_W + 2;
  localparam int unsigned DENV_W = 2*T_W;

  // Configuration registers; T^2 is registered from the duration and follows it in the next
  // cycle (4*T^2 is T^2 shifted by two), well before any item reaches the divider.
  logic signed [POS_W-1:0] start_r, end_r;
  logic [T_W-1:0]          dur_r;
  logic [DENV_W-1:0]       tt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      dur_r   <= DUR_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_START: start_r <= cfg_wdata;
        REG_END:   end_r   <= cfg_wdata;
        REG_DUR:   dur_r   <= cfg_wdata[T_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tt_r <= dur_r * dur_r;
  end

  // Global advance: hold everything while the output item is blocked.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: classify phase, distance magnitude, ramp time.
  logic              v1_r;
  phase_t            ph1_r;
  logic              neg1_r;
  logic [POS_W-1:0]  mag1_r;
  logic [T_W-1:0]    x1_r;
  logic [T_W+1:0]    cd1_r;

  logic [T_W+1:0]    t3;
  logic [POS_W:0]    span;
  phase_t            ph_nxt;

  always_comb begin
    t3   = (T_W+2)'(in_elapsed_ms) * (T_W+2)'(3);
    span = (POS_W+1)'(end_r) - (POS_W+1)'(start_r);
    if (in_elapsed_ms >= dur_r)                 ph_nxt = PH_DONE;
    else if (t3 < (T_W+2)'(dur_r))              ph_nxt = PH_RAMP_UP;
    else if (t3 < ((T_W+2)'(dur_r) << 1))       ph_nxt = PH_CRUISE;
    else                                        ph_nxt = PH_RAMP_DOWN;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph1_r  <= ph_nxt;
      neg1_r <= span[POS_W];
      mag1_r <= span[POS_W] ? POS_W'(-span) : span[POS_W-1:0];
      x1_r   <= (ph_nxt == PH_RAMP_UP) ? in_elapsed_ms : T_W'(dur_r - in_elapsed_ms);
      cd1_r  <= (T_W+2)'((t3 << 1) - (T_W+3)'(dur_r));
    end
  end

  // Stage 2: x^2, (6t - T)*T and the velocity factor.
  logic              v2_r;
  phase_t            ph2_r;
  logic              neg2_r;
  logic [POS_W-1:0]  mag2_r;
  logic [2*T_W-1:0]  xx2_r;
  logic [APOS_W-1:0] ct2_r;
  logic [AVEL_W-1:0] vf2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph2_r  <= ph1_r;
      neg2_r <= neg1_r;
      mag2_r <= mag1_r;
      xx2_r  <= x1_r * x1_r;
      ct2_r  <= APOS_W'(cd1_r) * APOS_W'(dur_r);
      vf2_r  <= (ph1_r == PH_CRUISE) ? AVEL_W'(dur_r * K_CRUISE) : AVEL_W'(x1_r * K_RAMP);
    end
  end

  // Stage 3: select the position factor (9x^2 on ramps, (6t-T)T in cruise).
  logic              v3_r;
  phase_t            ph3_r;
  logic              neg3_r;
  logic [POS_W-1:0]  mag3_r;
  logic [APOS_W-1:0] ap3_r;
  logic [AVEL_W-1:0] vf3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph3_r  <= ph2_r;
      neg3_r <= neg2_r;
      mag3_r <= mag2_r;
      ap3_r  <= (ph2_r == PH_CRUISE) ? ct2_r
                                     : APOS_W'({2'b00, xx2_r, 3'b000} + (2*T_W+5)'(xx2_r));
      vf3_r  <= vf2_r;
    end
  end

  // Stage 4: scale by distance magnitude.
  logic              v4_r;
  phase_t            ph4_r;
  logic              neg4_r;
  logic [NUMP_W-1:0] nump4_r;
  logic [NUMV_W-1:0] numv4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph4_r   <= ph3_r;
      neg4_r  <= neg3_r;
      nump4_r <= mag3_r * ap3_r;
      numv4_r <= mag3_r * vf3_r;
    end
  end

  // Velocity saturates when the quotient reaches 2^31.
  side_t side_in;
  always_comb begin
    side_in.ph  = ph4_r;
    side_in.neg = neg4_r;
    side_in.sat = (DENV_W+1)'(numv4_r[NUMV_W-1:POS_W-1]) >= (DENV_W+1)'(tt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Divider stages: side info and valid bits travel alongside.
  logic [QUO_W-1:0] qpos, qvel;

  tmp_div #(.NUM_W(NUMP_W), .DEN_W(DENP_W), .QUO_W(QUO_W)) u_div_pos (
    .clk (clk), .en (adv), .num (nump4_r), .den ({tt_r, 2'b00}), .quo (qpos)
  );

  tmp_div #(.NUM_W(NUMV_W), .DEN_W(DENV_W), .QUO_W(QUO_W)) u_div_vel (
    .clk (clk), .en (adv), .num (numv4_r), .den (tt_r), .quo (qvel)
  );

  logic  dv_r   [QUO_W];
  side_t side_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) dv_r[i] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= v4_r;
      for (int i = 1; i < QUO_W; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < QUO_W; i++) side_r[i] <= side_r[i-1];
    end
  end

  // Output stage: apply sign, base position and saturation.
  side_t                   so;
  logic signed [POS_W-1:0] pos_nxt, vel_nxt;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] pos_r, vel_r;
  phase_t                  ph_r;

  always_comb begin
    so = side_r[QUO_W-1];
    case (so.ph)
      PH_DONE:      pos_nxt = end_r;
      PH_RAMP_DOWN: pos_nxt = so.neg ? end_r + $signed(qpos) : end_r - $signed(qpos);
      default:      pos_nxt = so.neg ? start_r - $signed(qpos) : start_r + $signed(qpos);
    endcase
    if (so.ph == PH_DONE)  vel_nxt = '0;
    else if (so.sat)       vel_nxt = so.neg ? {1'b1, {(POS_W-1){1'b0}}}
                                            : {1'b0, {(POS_W-1){1'b1}}};
    else                   vel_nxt = so.neg ? -$signed(qvel) : $signed(qvel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
      ph_r  <= so.ph;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_target_position = pos_r;
  assign out_target_velocity = vel_r;
  assign out_move_phase      = ph_r;

`ifndef SYNTHESIS
  a_done_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_phase == PH_DONE |-> out_target_velocity == '0)
    else $error("finished item with nonzero velocity");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_phase == PH_DONE |-> out_target_position == end_r)
    else $error("finished item not at end position");

  a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target_position >= start_r && out_target_position <= end_r) ||
                  (out_target_position <= start_r && out_target_position >= end_r))
    else $error("position outside start/end span");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(dv_r[0]) && $stable(v4_r))
    else $error("pipeline moved while output blocked");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for trapezoidal_motion_profile: tick items in, set-points out.
// Depends on tmp_pkg and the RTL; predicts each set-point and compares it field by field.
`timescale 1ns / 1ps

module tb;
  import tmp_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
    phase_t                  ph;
  } setpoint_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [T_W-1:0]          in_elapsed_ms = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] out_target_position;
  logic signed [POS_W-1:0] out_target_velocity;
  logic [1:0]              out_move_phase;
  logic                    cfg_we = 1'b0;
  reg_idx_t                cfg_index = REG_START;
  logic [POS_W-1:0]        cfg_wdata = '0;

  // Our own copy of the move registers, mirrored on every write.
  logic signed [POS_W-1:0] move_start = '0;
  logic signed [POS_W-1:0] move_end = '0;
  logic [T_W-1:0]          move_dur = DUR_RESET;

  setpoint_t setpoint_q[$];
  int        mismatch_cnt = 0;
  bit        rx_hold = 1'b0;   // long receiver hold-off for the pressure test
  int        burst_left = 0;

  always #1 clk = ~clk;

  trapezoidal_motion_profile dut (.*);

  // Clamp a velocity magnitude to the signed 32 bit range, sign by direction.
  function automatic logic signed [POS_W-1:0] clamp_vel(bit [127:0] mag, bit neg);
    if (neg) return (mag >= 128'h8000_0000) ? 32'sh8000_0000 : -mag[31:0];
    return (mag > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
  endfunction

  // Expected set-point for one tick under the current move registers.
  function automatic setpoint_t profile_at(logic [T_W-1:0] tick);
    setpoint_t   r;
    longint      span;
    bit          neg;
    bit [127:0]  mag, t, dur, s, den, q;
    span = longint'(move_end) - longint'(move_start);
    neg  = span < 0;
    mag  = neg ? 128'(-span) : 128'(span);
    t    = 128'(tick);
    dur  = 128'(move_dur);
    den  = 4 * dur * dur;
    if (t >= dur) begin
      r.ph  = PH_DONE;
      r.pos = move_end;
      r.vel = '0;
    end else if (3 * t < dur) begin
      r.ph  = PH_RAMP_UP;
      q     = (9 * t * t * mag) / den;
      r.pos = neg ? move_start - q[31:0] : move_start + q[31:0];
      r.vel = clamp_vel((K_RAMP * mag * t) / (dur * dur), neg);
    end else if (3 * t < 2 * dur) begin
      r.ph  = PH_CRUISE;
      q     = (mag * (6 * t - dur)) / (4 * dur);
      r.pos = neg ? move_start - q[31:0] : move_start + q[31:0];
      r.vel = clamp_vel((K_CRUISE * mag) / dur, neg);
    end else begin
      r.ph  = PH_RAMP_DOWN;
      s     = dur - t;
      q     = (9 * s * s * mag) / den;
      // ramp down approaches end from the start side
      r.pos = neg ? move_end + q[31:0] : move_end - q[31:0];
      r.vel = clamp_vel((K_RAMP * mag * s) / (dur * dur), neg);
    end
    return r;
  endfunction

  // Drain the pipeline, then let the block settle before touching registers.
  task automatic wait_drained();
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [POS_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      REG_START: move_start = val;
      REG_END:   move_end = val;
      default:   move_dur = val[T_W-1:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_move(logic [POS_W-1:0] from, logic [POS_W-1:0] to, logic [T_W-1:0] dur);
    wait_drained();
    write_reg(REG_START, from);
    write_reg(REG_END, to);
    write_reg(REG_DUR, 32'(dur));
  endtask

  // Offer one tick; hold it until accepted, then maybe idle between bursts.
  task automatic send_tick(logic [T_W-1:0] tick);
    @(negedge clk);
    in_valid      = 1'b1;
    in_elapsed_ms = tick;
    do @(posedge clk); while (in_stall);
    setpoint_q.push_back(profile_at(tick));
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid      = 1'b0;
      in_elapsed_ms = T_W'($urandom);
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Receiver stall pattern: switches between none, random and toggling; rx_hold holds it stalled.
  initial begin : rx_pattern
    int mode;
    mode = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat (64) begin
        @(negedge clk);
        if (rx_hold) out_stall = 1'b1;
        else case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 99) < 30);
          2: out_stall = ~out_stall;
          default: out_stall = ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // Check every accepted set-point against the oldest prediction.
  always @(posedge clk) begin
    setpoint_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (setpoint_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected set-point pos=%0d", out_target_position);
      end else begin
        e = setpoint_q.pop_front();
        if (out_target_position !== e.pos || out_target_velocity !== e.vel ||
            out_move_phase !== e.ph) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("set-point mismatch: exp pos=%0d vel=%0d ph=%0d got pos=%0d vel=%0d ph=%0d",
                     e.pos, e.vel, e.ph, out_target_position, out_target_velocity,
                     out_move_phase);
        end
      end
    end
  end

  // Reset values, then each phase and the edges of the tick range.
  task automatic test_phases_and_extremes();
    // reset registers: zero distance, 1000 ms
    send_tick(16'd0);
    send_tick(16'd500);
    send_tick(16'hFFFF);
    end_burst();
    // widest positive move, short duration: velocity saturates
    set_move(32'h8000_0000, 32'h7FFF_FFFF, 16'd3);
    send_tick(16'd0); send_tick(16'd1); send_tick(16'd2); send_tick(16'd3);
    end_burst();
    set_move(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_tick(16'd0); send_tick(16'd21845); send_tick(16'd43690);
    send_tick(16'd43689); send_tick(16'hFFFE); send_tick(16'hFFFF);
    end_burst();
    set_move(32'h0001_0000, 32'hFFFF_0000, 16'd1000);
    send_tick(16'd333); send_tick(16'd334); send_tick(16'd666); send_tick(16'd667);
    end_burst();
  endtask

  // Durations below three: zero means always finished, one and two still ramp.
  task automatic test_short_durations();
    set_move(32'h0010_0000, 32'h0020_0000, 16'd0);
    send_tick(16'd0); send_tick(16'd5);
    end_burst();
    set_move(32'h0010_0000, 32'hFFF0_0000, 16'd1);
    send_tick(16'd0); send_tick(16'd1);
    end_burst();
    set_move(32'h0010_0000, 32'h0020_0000, 16'd2);
    send_tick(16'd0); send_tick(16'd1); send_tick(16'd2);
    end_burst();
  endtask

  // Random moves; ticks mostly within the move, some beyond it.
  task automatic test_random_moves();
    logic [POS_W-1:0] from, to;
    logic [T_W-1:0]   dur;
    for (int m = 0; m < 9; m++) begin
      from = $urandom;
      to   = ($urandom_range(0, 3) == 0) ? $urandom : from + ($urandom >> $urandom_range(4, 12));
      if (m == 0) to = 32'h7FFF_FFFF;
      if (m == 1) from = 32'h8000_0000;
      dur = ($urandom_range(0, 4) == 0) ? T_W'($urandom_range(3, 65535))
                                        : T_W'($urandom_range(3, 2000));
      set_move(from, to, dur);
      repeat (45) begin
        if ($urandom_range(0, 9) == 0) send_tick(T_W'($urandom));
        else send_tick(T_W'($urandom_range(0, int'(dur) + int'(dur) / 8)));
      end
      end_burst();
    end
  endtask

  // Hold the receiver off long enough to fill the pipeline and stall the sender.
  task automatic test_backpressure();
    set_move(32'hFFF0_0000, 32'h0100_0000, 16'd1200);
    fork
      begin
        rx_hold = 1'b1;
        repeat (150) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        repeat (50) send_tick(T_W'($urandom_range(0, 1300)));
        end_burst();
      end
    join
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_phases_and_extremes();
    test_short_durations();
    test_random_moves();
    test_backpressure();
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && setpoint_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
